// ===== rtl/cmzc_pkg.sv =====
// shared constants and codes for the compass message zero calibration unit
`timescale 1ns / 1ps

package cmzc_pkg;

    // default number of headings summed as the zero reference
    localparam int unsigned CALIB_SAMPLES_DEF = 15;

    localparam int unsigned MIN_LENGTH    = 4;
    localparam int unsigned HEADING_LIMIT = 3600;
    localparam int unsigned HALF_CIRCLE   = 1800;
    localparam int unsigned FULL_CIRCLE   = 3600;

    localparam logic [7:0] ERR_MASK_RST = 8'h80;

    typedef enum logic [2:0] {
        ST_VALID       = 3'd0,
        ST_CALIBRATING = 3'd1,
        ST_SHORT       = 3'd2,
        ST_DEVERR      = 3'd3,
        ST_RANGE       = 3'd4,
        ST_DONE        = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        COND_NOT_INIT = 2'd0,
        COND_VALID    = 2'd1,
        COND_ERROR    = 2'd2
    } t_sensor;

endpackage

// ===== rtl/compass_message_zero_calibration_unit.sv =====
// compass message checker with zero-reference calibration and heading correction
`timescale 1ns / 1ps

// usage
//   s_axis: one transaction per compass message, tdata carries msg_length,
//     device_state, heading_high, heading_low (8 bits each, lowest first)
//   m_axis: exactly one result transaction per message, in order; tdata
//     carries status, heading, sensor_state, valid_count
//   i_cfg_wr_en / i_cfg_wr_data: writes error_bit_mask, only while idle
// timing
//   a message is captured in an input register, checked and corrected by
//   one level of compares, a constant multiply, a subtract and a wrap, and
//   lands in the result register; throughput is one message per cycle
//   while m_axis_tready is high, and all state is updated in the single
//   compute step, so each message sees what the previous one left
// reset
//   clears calibration count, zero sum, calibrated flag, sensor state
//   (not initialized), message counter and both valid bits; mask = 0x80
// stall
//   when m_axis_tready is low the result holds, the input register still
//   fills, and s_axis_tready drops once both stages are occupied
module compass_message_zero_calibration_unit #(
    parameter int unsigned CALIB_SAMPLES = cmzc_pkg::CALIB_SAMPLES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    // message input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] msg_length, [15:8] device_state, [23:16] heading_high,
    // [31:24] heading_low
    input  logic [31:0] s_axis_tdata,
    // result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] status, [18:3] heading, [20:19] sensor_state,
    // [52:21] valid_count, [55:53] zero
    output logic [55:0] m_axis_tdata
);
    import cmzc_pkg::*;

    // sum of CALIB_SAMPLES headings below 3600 stays below CALIB_SAMPLES*3600
    localparam int unsigned SUM_W = $clog2(CALIB_SAMPLES * FULL_CIRCLE);
    localparam int unsigned D_W   = SUM_W + 1;
    localparam int unsigned EXT_W = (D_W > 16) ? D_W : 16;
    localparam int unsigned CNT_W = $clog2(CALIB_SAMPLES + 1);

    localparam logic signed [D_W-1:0] HALF_S = D_W'(CALIB_SAMPLES * HALF_CIRCLE);
    localparam logic signed [D_W-1:0] FULL_S = D_W'(CALIB_SAMPLES * FULL_CIRCLE);

    // configuration register
    logic [7:0] r_err_mask;

    // input register
    logic       r_in_vld;
    logic [7:0] r_len;
    logic [7:0] r_dev;
    logic [15:0] r_raw;

    // block state
    logic [CNT_W-1:0] r_calib_cnt, n_calib_cnt;
    logic [SUM_W-1:0] r_zero_sum, n_zero_sum;
    logic             r_calibrated, n_calibrated;
    t_sensor          r_sensor, n_sensor;
    logic [31:0]      r_valid_msgs, n_valid_msgs;

    // result register
    logic                r_out_vld;
    t_status             r_status, n_status;
    logic signed [15:0]  r_heading, n_heading;

    logic advance;

    // the compute step moves whenever the result register is free or drains
    assign advance       = !r_out_vld || m_axis_tready;
    assign s_axis_tready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_mask <= ERR_MASK_RST;
        end else if (i_cfg_wr_en) begin
            r_err_mask <= i_cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_len <= s_axis_tdata[7:0];
            r_dev <= s_axis_tdata[15:8];
            r_raw <= {s_axis_tdata[23:16], s_axis_tdata[31:24]};
        end
    end

    // heading correction: N*raw - sum wrapped to [-N*1800, N*1800)
    logic [11:0]          raw12;
    logic [SUM_W-1:0]     prod;
    logic signed [D_W-1:0] diff;
    logic signed [D_W-1:0] wrapped;
    logic signed [EXT_W-1:0] wrapped_ext;

    assign raw12 = r_raw[11:0];
    assign prod  = SUM_W'(SUM_W'(CALIB_SAMPLES) * SUM_W'(raw12));
    assign diff  = $signed({1'b0, prod}) - $signed({1'b0, r_zero_sum});

    always_comb begin
        if (diff >= HALF_S) begin
            wrapped = diff - FULL_S;
        end else if (diff < -HALF_S) begin
            wrapped = diff + FULL_S;
        end else begin
            wrapped = diff;
        end
    end

    assign wrapped_ext = EXT_W'(wrapped);

    // message checks and state update
    always_comb begin
        n_calib_cnt  = r_calib_cnt;
        n_zero_sum   = r_zero_sum;
        n_calibrated = r_calibrated;
        n_sensor     = r_sensor;
        n_valid_msgs = r_valid_msgs;
        n_heading    = '0;

        if (r_len < 8'(MIN_LENGTH)) begin
            n_status = ST_SHORT;
            n_sensor = COND_ERROR;
        end else if ((r_dev & r_err_mask) != 8'd0) begin
            n_status = ST_DEVERR;
            n_sensor = COND_ERROR;
        end else if (r_raw >= 16'(HEADING_LIMIT)) begin
            n_status = ST_RANGE;
            n_sensor = COND_ERROR;
        end else begin
            n_valid_msgs = r_valid_msgs + 32'd1;
            if (r_calibrated) begin
                n_status  = ST_VALID;
                n_sensor  = COND_VALID;
                n_heading = wrapped_ext[15:0];
            end else if (r_calib_cnt < CNT_W'(CALIB_SAMPLES)) begin
                // still collecting the zero reference
                n_status    = ST_CALIBRATING;
                n_zero_sum  = r_zero_sum + SUM_W'(raw12);
                n_calib_cnt = r_calib_cnt + CNT_W'(1);
            end else begin
                // one extra valid message closes calibration
                n_status     = ST_DONE;
                n_calibrated = 1'b1;
            end
        end
    end

    wire step = r_in_vld && advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calib_cnt  <= '0;
            r_zero_sum   <= '0;
            r_calibrated <= 1'b0;
            r_sensor     <= COND_NOT_INIT;
            r_valid_msgs <= '0;
            r_out_vld    <= 1'b0;
        end else begin
            if (advance) begin
                r_out_vld <= r_in_vld;
            end
            if (step) begin
                r_calib_cnt  <= n_calib_cnt;
                r_zero_sum   <= n_zero_sum;
                r_calibrated <= n_calibrated;
                r_sensor     <= n_sensor;
                r_valid_msgs <= n_valid_msgs;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_status  <= n_status;
            r_heading <= n_heading;
        end
    end

    // sensor state and counter registers already hold the post-message values
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {3'b000, r_valid_msgs, r_sensor, r_heading, r_status};

endmodule

// ===== bench/tb_top.sv =====
// self-checking bench for the compass message zero calibration unit
`timescale 1ns / 1ps

module tb_top;
    import cmzc_pkg::*;

    localparam int CALIB_N      = int'(CALIB_SAMPLES_DEF);
    localparam int HALF_SPAN    = CALIB_N * int'(HALF_CIRCLE);
    localparam int STALL_LIMIT  = 4000;
    localparam int SETTLE_CYCLES = 6;

    typedef struct {
        t_status            status;
        logic signed [15:0] heading;
        t_sensor            sensor;
        logic [31:0]        count;
    } t_heading_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [7:0]  i_cfg_wr_data = 8'h00;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [7:0] msg_length, [15:8] device_state, [23:16] heading_high, [31:24] heading_low
    logic [31:0] s_axis_tdata = 32'h0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [2:0] status, [18:3] heading, [20:19] sensor_state, [52:21] valid_count
    logic [55:0] m_axis_tdata;

    compass_message_zero_calibration_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // shadow copy of the block state
    logic [7:0]  shadow_mask = ERR_MASK_RST;
    int          shadow_calib_cnt = 0;
    logic [15:0] shadow_zero_sum = 16'h0;
    bit          shadow_calibrated = 1'b0;
    t_sensor     shadow_sensor = COND_NOT_INIT;
    logic [31:0] shadow_valid_cnt = 32'h0;

    t_heading_result pending_headings[$];
    int mismatches = 0;
    int stall_cycles = 0;
    int src_idle_pct = 0;
    int snk_idle_pct = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // result side backpressure
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // works out the result of one message and advances the shadow state
    function automatic t_heading_result correct_heading(input logic [7:0] len,
                                                        input logic [7:0] dev,
                                                        input logic [15:0] raw);
        t_heading_result r;
        int diff;
        r.status  = ST_VALID;
        r.heading = 16'sd0;
        if (len < MIN_LENGTH) begin
            r.status = ST_SHORT;
            shadow_sensor = COND_ERROR;
        end else if ((dev & shadow_mask) != 8'h00) begin
            r.status = ST_DEVERR;
            shadow_sensor = COND_ERROR;
        end else if (raw >= HEADING_LIMIT) begin
            r.status = ST_RANGE;
            shadow_sensor = COND_ERROR;
        end else begin
            shadow_valid_cnt = shadow_valid_cnt + 32'd1;
            if (shadow_calibrated) begin
                diff = CALIB_N * int'(raw) - int'(shadow_zero_sum);
                // wrap into the half-open circle
                if (diff >= HALF_SPAN)
                    diff = diff - 2 * HALF_SPAN;
                else if (diff < -HALF_SPAN)
                    diff = diff + 2 * HALF_SPAN;
                r.heading = diff[15:0];
                r.status = ST_VALID;
                shadow_sensor = COND_VALID;
            end else if (shadow_calib_cnt < CALIB_N) begin
                shadow_zero_sum = shadow_zero_sum + raw;
                shadow_calib_cnt++;
                r.status = ST_CALIBRATING;
            end else begin
                shadow_calibrated = 1'b1;
                r.status = ST_DONE;
            end
        end
        r.sensor = shadow_sensor;
        r.count  = shadow_valid_cnt;
        return r;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_heading_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_headings.size() == 0) begin
                mismatches++;
                if (mismatches < 100)
                    $display("%0t unexpected result transaction, got %h", $time, m_axis_tdata);
            end else begin
                want = pending_headings.pop_front();
                if (m_axis_tdata[2:0] !== want.status) begin
                    mismatches++;
                    if (mismatches < 100)
                        $display("%0t status: expected %0d, actual %0d",
                                 $time, want.status, m_axis_tdata[2:0]);
                end
                if (m_axis_tdata[18:3] !== want.heading) begin
                    mismatches++;
                    if (mismatches < 100)
                        $display("%0t heading: expected %0d, actual %0d",
                                 $time, want.heading, $signed(m_axis_tdata[18:3]));
                end
                if (m_axis_tdata[20:19] !== want.sensor) begin
                    mismatches++;
                    if (mismatches < 100)
                        $display("%0t sensor_state: expected %0d, actual %0d",
                                 $time, want.sensor, m_axis_tdata[20:19]);
                end
                if (m_axis_tdata[52:21] !== want.count) begin
                    mismatches++;
                    if (mismatches < 100)
                        $display("%0t valid_count: expected %0d, actual %0d",
                                 $time, want.count, m_axis_tdata[52:21]);
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL compass_message_zero_calibration_unit");
            $finish;
        end
    end

    task automatic send_msg(input logic [7:0] len, input logic [7:0] dev,
                            input logic [15:0] raw);
        while ($urandom_range(99) < src_idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {raw[7:0], raw[15:8], dev, len};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        pending_headings.push_back(correct_heading(len, dev, raw));
    endtask

    // drop valid and let every outstanding result come back
    task automatic hold_until_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_headings.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mask(input logic [7:0] value);
        hold_until_drained();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        shadow_mask = value;
    endtask

    // mostly well-formed messages, the rest altered in one of four ways that may break them
    task automatic send_random_msg();
        logic [7:0]  len;
        logic [7:0]  dev;
        logic [15:0] raw;
        len = 8'($urandom_range(255, 4));
        dev = 8'($urandom) & ~shadow_mask;
        raw = 16'($urandom_range(3599));
        if ($urandom_range(99) >= 70) begin
            case ($urandom_range(3))
                0: len = 8'($urandom_range(3));
                1: dev = 8'($urandom);
                2: begin
                    len = 8'($urandom);
                    dev = 8'($urandom);
                    raw = 16'($urandom);
                end
                default: raw = 16'($urandom_range(3605, 3595));
            endcase
        end
        send_msg(len, dev, raw);
    endtask

    // rejections before calibration, the calibration run, then corrected
    // headings including the wrap edge; zero sum comes to 13500
    task automatic test_calibration();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        send_msg(8'd0, 8'h00, 16'd100);     // empty message
        send_msg(8'd3, 8'h00, 16'd100);     // one byte short
        send_msg(8'd4, 8'h80, 16'd0);       // error bit under reset mask
        send_msg(8'd4, 8'h7F, 16'd3600);    // first heading out of range
        send_msg(8'd255, 8'h00, 16'hFFFF);
        send_msg(8'd4, 8'h7F, 16'd0);       // calibration starts, state still error
        send_msg(8'd255, 8'h00, 16'd3599);
        for (int k = 0; k < 12; k++)
            send_msg(8'd8, 8'h00, 16'd761);
        send_msg(8'd8, 8'h00, 16'd769);
        send_msg(8'd4, 8'h00, 16'd1234);    // only ends calibration
        send_msg(8'd4, 8'h00, 16'd0);
        send_msg(8'd4, 8'h00, 16'd2699);    // just below the wrap
        send_msg(8'd4, 8'h00, 16'd2700);    // lands on the wrap point
        send_msg(8'd4, 8'h00, 16'd3599);
        send_msg(8'd4, 8'hFF, 16'd900);     // device error after calibration
        send_msg(8'd4, 8'h00, 16'd900);     // back to zero, state valid
    endtask

    task automatic test_mask_extremes();
        write_mask(8'h00);
        repeat (30) send_random_msg();
        write_mask(8'hFF);
        repeat (30) send_random_msg();
        write_mask(ERR_MASK_RST);
    endtask

    task automatic test_random_traffic(input int src_pct, input int snk_pct,
                                       input int count);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        write_mask(8'($urandom_range(255)));
        repeat (count / 2) send_random_msg();
        // sender waits for every result before the mask moves again
        write_mask(8'($urandom_range(255)));
        repeat (count - count / 2) send_random_msg();
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_calibration();
        test_mask_extremes();
        test_random_traffic(20, 83, 500);
        test_random_traffic(83, 20, 500);
        test_random_traffic(0, 0, 500);

        hold_until_drained();
        if (mismatches == 0 && pending_headings.size() == 0)
            $display("PASS compass_message_zero_calibration_unit");
        else
            $display("FAIL compass_message_zero_calibration_unit");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/cmzc_pkg.sv
rtl/compass_message_zero_calibration_unit.sv
bench/tb_top.sv
